// File: rtl/sme_pkg.sv
// ----------------------------------------------------------------------------
// sme_pkg
// Shared types and constants for the stack machine executor: opcodes,
// status codes and the instruction and result payload structs.
// ----------------------------------------------------------------------------
package sme_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned IDX_W           = 4;
  localparam int unsigned IDX_SPAN        = 1 << IDX_W;  // entries reachable by a copy
  localparam int unsigned DEPTH_OUT_W     = 5;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_MUL  = 3'd2,
    OP_COPY = 3'd3,
    OP_POP  = 3'd4,
    OP_SWAP = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_OVER  = 3'd2,
    ST_RANGE = 3'd3,
    ST_FINAL = 3'd4
  } status_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] imm_value;
    logic [IDX_W-1:0]   depth_index;
    logic               last_instr;
  } instr_t;

  typedef struct packed {
    logic [2:0]             status;
    logic signed [31:0]     top_value;
    logic [DEPTH_OUT_W-1:0] stack_depth;
    logic                   done_res;
  } result_t;

endpackage

// File: rtl/sme_stack.sv
// ----------------------------------------------------------------------------
// sme_stack
// Operand stack held as a shift line (entry 0 is the top) plus the ALU.
// Executes one instruction when exec_en is high and presents its result.
// ----------------------------------------------------------------------------
module sme_stack
  import sme_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    exec_en,
  input  instr_t  instr,
  output result_t result
);

  localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int unsigned COPY_N = (STACK_DEPTH < IDX_SPAN) ? STACK_DEPTH : IDX_SPAN;

  logic [31:0]      stk_r   [STACK_DEPTH];
  logic [31:0]      stk_nxt [STACK_DEPTH];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W-1:0] cnt_exec;

  logic [31:0] sum;
  logic [31:0] prod;
  logic [31:0] copy_val;
  logic        is_full;
  logic        lt_two;
  logic        idx_bad;
  status_t     st;

  assign sum     = stk_r[0] + stk_r[1];
  assign prod    = stk_r[0] * stk_r[1];
  assign is_full = (cnt_r >= CNT_W'(STACK_DEPTH));
  assign lt_two  = (cnt_r < CNT_W'(2));
  assign idx_bad = (CMP_W'(instr.depth_index) >= CMP_W'(cnt_r));

  always_comb begin
    copy_val = stk_r[0];
    for (int i = 0; i < COPY_N; i++) begin
      if (instr.depth_index == IDX_W'(i)) copy_val = stk_r[i];
    end
  end

  always_comb begin
    st       = ST_OK;
    cnt_exec = cnt_r;
    for (int i = 0; i < STACK_DEPTH; i++) stk_nxt[i] = stk_r[i];

    unique case (instr.op)
      OP_PUSH, OP_COPY: begin
        if (instr.op == OP_COPY && idx_bad) begin
          st = ST_RANGE;
        end else if (is_full) begin
          st = ST_OVER;
        end else begin
          stk_nxt[0] = (instr.op == OP_PUSH) ? instr.imm_value : copy_val;
          for (int i = 1; i < STACK_DEPTH; i++) stk_nxt[i] = stk_r[i-1];
          cnt_exec = cnt_r + CNT_W'(1);
        end
      end
      OP_ADD, OP_MUL: begin
        if (lt_two) begin
          st = ST_UNDER;
        end else begin
          stk_nxt[0] = (instr.op == OP_ADD) ? sum : prod;
          for (int i = 1; i < STACK_DEPTH - 1; i++) stk_nxt[i] = stk_r[i+1];
          cnt_exec = cnt_r - CNT_W'(1);
        end
      end
      OP_POP: begin
        if (cnt_r == '0) begin
          st = ST_UNDER;
        end else begin
          for (int i = 0; i < STACK_DEPTH - 1; i++) stk_nxt[i] = stk_r[i+1];
          cnt_exec = cnt_r - CNT_W'(1);
        end
      end
      OP_SWAP: begin
        if (lt_two) begin
          st = ST_UNDER;
        end else begin
          stk_nxt[0] = stk_r[1];
          stk_nxt[1] = stk_r[0];
        end
      end
      default: ;  // unused opcodes leave the stack alone
    endcase

    // final instruction: check depth, then empty the stack
    cnt_nxt = cnt_exec;
    if (instr.last_instr) begin
      if (st == ST_OK && cnt_exec != CNT_W'(1)) st = ST_FINAL;
      cnt_nxt = '0;
    end
  end

  always_comb begin
    result.status      = st;
    result.top_value   = (cnt_exec == '0) ? 32'sd0 : stk_nxt[0];
    result.stack_depth = DEPTH_OUT_W'(cnt_exec);
    result.done_res    = instr.last_instr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (exec_en) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_en) begin
      for (int i = 0; i < STACK_DEPTH; i++) stk_r[i] <= stk_nxt[i];
    end
  end

endmodule

// File: rtl/stack_machine_executor_core.sv
// ----------------------------------------------------------------------------
// stack_machine_executor_core
// Executes one stack-machine instruction per transfer and returns one result.
// ----------------------------------------------------------------------------
// Each instruction executes out of the input register once the output register
// is free or draining; an output stall holds it there. Its result is then
// registered in the output register, and a new instruction is taken every cycle
// while the output does not stall. The stack is a shift line with the top entry
// at a fixed place, so each instruction reads the stack combinationally and
// writes it back as it executes. The adder or the 32x32 multiplier is the longest
// path. The stack needs no clearing after reset; only the entry count is reset.
// ----------------------------------------------------------------------------
module stack_machine_executor_core
  import sme_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  instr_t  in_data,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    in_vld_r;
  logic    in_vld_nxt;
  instr_t  in_q_r;
  logic    out_vld_r;
  logic    out_vld_nxt;
  result_t out_q_r;
  result_t exec_res;
  logic    exec_go;
  logic    exec_en;
  logic    in_load;

  // output register free or draining this cycle
  assign exec_go  = !out_vld_r || !out_stall;
  assign exec_en  = exec_go && in_vld_r;
  assign in_stall = in_vld_r && !exec_go;
  assign in_load  = in_valid && !in_stall;

  assign out_valid = out_vld_r;
  assign out_data  = out_q_r;

  sme_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk    (clk),
    .rst_n  (rst_n),
    .exec_en(exec_en),
    .instr  (in_q_r),
    .result (exec_res)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_load) in_vld_nxt = 1'b1;
    else if (exec_go) in_vld_nxt = 1'b0;
    out_vld_nxt = out_vld_r;
    if (exec_go) out_vld_nxt = in_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) in_q_r <= in_data;
    if (exec_en) out_q_r <= exec_res;
  end

`ifndef ASSERT_OFF
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |-> !in_stall)
    else $error("input stalled with empty input register");

  a_final_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FINAL |-> out_data.done_res)
    else $error("final-depth status on a result that does not end a program");

  a_empty_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (STACK_DEPTH < 32) && out_valid && out_data.stack_depth == '0
    |-> out_data.top_value == 32'sd0)
    else $error("nonzero top value reported for an empty stack");

  a_result_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
    exec_en |=> out_valid)
    else $error("executed instruction produced no result");
`endif

endmodule
